[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dsa_pkg.sv]
`timescale 1ns / 1ps

package dsa_pkg;

    localparam int STATE_W = 6;
    localparam int SYM_W   = 8;

    typedef enum logic [1:0] {
        MODE_WR_EDGE = 2'd0,
        MODE_WR_ACC  = 2'd1,
        MODE_BYTE    = 2'd2,
        MODE_END     = 2'd3
    } mode_t;

    // one transition table entry
    typedef struct packed {
        logic               vld;
        logic [STATE_W-1:0] dst;
    } edge_t;

    localparam int EDGE_W = $bits(edge_t);

    typedef struct packed {
        logic accepted;
        logic hit_dead_end;
    } result_t;

endpackage

[rtl/dsa_if.sv]
`timescale 1ns / 1ps

interface dsa_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] src_state;
    logic [7:0] char_code;
    logic [5:0] dest_state;
    logic       edge_valid;
    logic       accepting_bit;

    modport source (
        output valid, mode, src_state, char_code, dest_state, edge_valid, accepting_bit,
        input  ready
    );
    modport sink (
        input  valid, mode, src_state, char_code, dest_state, edge_valid, accepting_bit,
        output ready
    );
endinterface

interface dsa_result_if;
    logic valid;
    logic ready;
    logic accepted;
    logic hit_dead_end;

    modport source (
        output valid, accepted, hit_dead_end,
        input  ready
    );
    modport sink (
        input  valid, accepted, hit_dead_end,
        output ready
    );
endinterface

[rtl/dsa_ram.sv]
`timescale 1ns / 1ps

module dsa_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16384
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dfa_string_acceptor.sv]
`timescale 1ns / 1ps

// channel   dir   transfer carries
// item      in    mode, src_state, char_code, dest_state, edge_valid, accepting_bit
// result    out   accepted, hit_dead_end (one per end-of-string item)
// cfg       in    start_state write (cfg_we, cfg_wdata), no read-back
//
// one item per cycle while item.ready is high; the tightest path is the table
// read data feeding the next state straight back into the table read address
// an end item's result passes through the second stage and is then registered
// in the result queue before it is valid
// after reset the tables are swept to zero over all 2**(SW+YW) table rows
// (16384 at the defaults); item.ready stays low meanwhile
// item.ready drops while four results are held or in flight

module dfa_string_acceptor
    import dsa_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dsa_item_if.sink             item,
    dsa_result_if.source         result,
    input  logic                 cfg_we,
    input  logic [STATE_W-1:0]   cfg_wdata
);

    localparam int SW  = NUM_STATES  > 1 ? $clog2(NUM_STATES)  : 1;
    localparam int YW  = NUM_SYMBOLS > 1 ? $clog2(NUM_SYMBOLS) : 1;
    localparam int AW  = SW + YW;
    localparam int SIW = SW > STATE_W ? SW : STATE_W;

    // state number to table row, zero extended or trimmed to the row width
    function automatic logic [SW-1:0] st_idx(input logic [STATE_W-1:0] s);
        logic [SIW-1:0] e;
        e = SIW'(s);
        return e[SW-1:0];
    endfunction

    function automatic logic [YW-1:0] sym_idx(input logic [SYM_W-1:0] c);
        return c[YW-1:0];
    endfunction

    // start state register
    logic [STATE_W-1:0] start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            start_reg <= cfg_wdata;
        end
    end

    // clearing sweep after reset
    logic          clr_reg;
    logic          clr_next;
    logic [AW-1:0] clr_cnt_reg;

    assign clr_next = clr_reg && (clr_cnt_reg != '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // input decode
    logic  accept;
    mode_t in_mode;
    logic  src_ok;
    logic  sym_ok;

    assign accept  = item.valid && item.ready;
    assign in_mode = mode_t'(item.mode);
    assign src_ok  = 32'(item.src_state) < NUM_STATES;
    assign sym_ok  = 32'(item.char_code) < NUM_SYMBOLS;

    // second stage: the item whose memory reads are now returning
    logic               v1_reg;
    mode_t              mode1_reg;
    logic               tbl_ok1_reg;
    logic               acc_ok1_reg;
    edge_t              tbl_rd;
    logic [0:0]         acc_rd;

    // matcher state, resolved at the second stage
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic               dead_reg;
    logic               dead_next;
    logic               push;
    result_t            res_new;

    always_comb
    begin
        state_next = state_reg;
        dead_next  = dead_reg;
        push       = 1'b0;
        res_new    = '0;
        if (v1_reg)
        begin
            unique case (mode1_reg)
                MODE_BYTE:
                begin
                    // a dead string ignores further bytes
                    if (!dead_reg)
                    begin
                        if (tbl_ok1_reg && tbl_rd.vld)
                        begin
                            state_next = tbl_rd.dst;
                        end
                        else
                        begin
                            dead_next = 1'b1;
                        end
                    end
                end
                MODE_END:
                begin
                    push                 = 1'b1;
                    res_new.accepted     = !dead_reg && acc_ok1_reg && acc_rd[0];
                    res_new.hit_dead_end = dead_reg;
                    state_next           = start_reg;
                    dead_next            = 1'b0;
                end
                MODE_WR_EDGE, MODE_WR_ACC:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            state_reg <= '0;
            dead_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= accept;
            state_reg <= state_next;
            dead_reg  <= dead_next;
        end
    end

    // the reads of a new item look up the state forwarded from the stage ahead
    always_ff @(posedge clk)
    begin
        mode1_reg   <= in_mode;
        tbl_ok1_reg <= (32'(state_next) < NUM_STATES) && sym_ok;
        acc_ok1_reg <= 32'(state_next) < NUM_STATES;
    end

    // transition table: write port for edge writes and the clearing sweep
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    edge_t         tbl_wdata;
    logic [AW-1:0] tbl_raddr;

    always_comb
    begin
        if (clr_reg)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = '0;
        end
        else
        begin
            tbl_we        = accept && (in_mode == MODE_WR_EDGE) && src_ok && sym_ok;
            tbl_waddr     = {st_idx(item.src_state), sym_idx(item.char_code)};
            tbl_wdata.vld = item.edge_valid;
            tbl_wdata.dst = item.edge_valid ? item.dest_state : '0;
        end
    end

    assign tbl_raddr = {st_idx(state_next), sym_idx(item.char_code)};

    dsa_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (2 ** AW)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rd)
    );

    // accepting flags, swept alongside the table
    logic          acc_we;
    logic [SW-1:0] acc_waddr;
    logic [0:0]    acc_wdata;

    always_comb
    begin
        if (clr_reg)
        begin
            acc_we    = 1'b1;
            acc_waddr = clr_cnt_reg[SW-1:0];
            acc_wdata = 1'b0;
        end
        else
        begin
            acc_we    = accept && (in_mode == MODE_WR_ACC) && src_ok;
            acc_waddr = st_idx(item.src_state);
            acc_wdata = item.accepting_bit;
        end
    end

    dsa_ram #(
        .WIDTH (1),
        .DEPTH (2 ** SW)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (st_idx(state_next)),
        .rdata (acc_rd)
    );

    // four-entry result queue between the matcher and the result port
    result_t    rq_reg [4];
    logic [1:0] rq_wr_reg;
    logic [1:0] rq_rd_reg;
    logic [2:0] rq_cnt_reg;
    logic       pop;
    logic       pend;

    assign pop  = result.valid && result.ready;
    assign pend = v1_reg && (mode1_reg == MODE_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                rq_wr_reg <= rq_wr_reg + 2'd1;
            end
            if (pop)
            begin
                rq_rd_reg <= rq_rd_reg + 2'd1;
            end
            rq_cnt_reg <= rq_cnt_reg + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rq_reg[rq_wr_reg] <= res_new;
        end
    end

    assign result.valid        = rq_cnt_reg != '0;
    assign result.accepted     = rq_reg[rq_rd_reg].accepted;
    assign result.hit_dead_end = rq_reg[rq_rd_reg].hit_dead_end;

    // room is kept for every result that could still land in the queue
    assign item.ready = !clr_reg && ((rq_cnt_reg + 3'(pend)) < 3'd4);

endmodule

[rtl/dsa_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsa_checker
    import dsa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic [1:0] item_mode,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_accepted,
    input logic       res_dead
);

    `ASSERT_CLK(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res_accepted) && $stable(res_dead), "result changed while stalled")

    `ASSERT_CLK(a_res_excl, clk, rst_n, res_valid |-> !(res_accepted && res_dead), "dead string reported as accepted")

    `ASSERT_CLK(a_res_cause, clk, rst_n, $rose(res_valid) |-> $past(item_valid && item_ready && (item_mode == MODE_END), 2), "result without an end-of-string transfer")

    `ASSERT_CLK_ALWAYS(a_clear_stall, clk, $past(!rst_n) |-> !item_ready, "item taken during table clearing")

endmodule

bind dfa_string_acceptor dsa_checker u_dsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_mode    (item.mode),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_accepted (result.accepted),
    .res_dead     (result.hit_dead_end)
);

[tb/dsa_match_checker.sv]
`timescale 1ns / 1ps

module dsa_match_checker
    import dsa_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    dsa_item_if                item,
    dsa_result_if              result,
    input  logic               cfg_we,
    input  logic [STATE_W-1:0] cfg_wdata,
    output int                 mismatches,
    output int                 pending_verdicts
);

    edge_t              edges    [NUM_STATES*NUM_SYMBOLS];
    logic               acc_flag [NUM_STATES];
    logic [STATE_W-1:0] start_reg;
    logic [STATE_W-1:0] cur_state;
    logic               dead;
    result_t            verdicts [$];

    always @(posedge clk or negedge rst_n)
    begin
        int      slot;
        edge_t   hop;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES*NUM_SYMBOLS; i++)
                edges[i] = '0;
            for (int i = 0; i < NUM_STATES; i++)
                acc_flag[i] = 1'b0;
            start_reg = '0;
            cur_state = '0;
            dead      = 1'b0;
            mismatches = 0;
            verdicts.delete();
            pending_verdicts <= 0;
        end
        else
        begin
            // results first: a result never belongs to an end item of the same edge
            if (result.valid && result.ready)
            begin
                if (verdicts.size() == 0)
                begin
                    $error("result transfer with no end of string pending");
                    mismatches++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (result.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0b, got %0b", want.accepted, result.accepted);
                        mismatches++;
                    end
                    if (result.hit_dead_end !== want.hit_dead_end)
                    begin
                        $error("hit_dead_end: expected %0b, got %0b",
                               want.hit_dead_end, result.hit_dead_end);
                        mismatches++;
                    end
                end
            end

            if (item.valid && item.ready)
            begin
                case (item.mode)
                    MODE_WR_EDGE:
                    begin
                        if (item.src_state < NUM_STATES && item.char_code < NUM_SYMBOLS)
                        begin
                            slot = int'(item.src_state) * NUM_SYMBOLS + int'(item.char_code);
                            if (item.edge_valid)
                                edges[slot] = '{vld: 1'b1, dst: item.dest_state};
                            else
                                edges[slot] = '0;
                        end
                    end
                    MODE_WR_ACC:
                    begin
                        if (item.src_state < NUM_STATES)
                            acc_flag[item.src_state] = item.accepting_bit;
                    end
                    MODE_BYTE:
                    begin
                        if (!dead)
                        begin
                            hop = '0;
                            if (cur_state < NUM_STATES && item.char_code < NUM_SYMBOLS)
                                hop = edges[int'(cur_state) * NUM_SYMBOLS + int'(item.char_code)];
                            if (hop.vld)
                                cur_state = hop.dst;
                            else
                                dead = 1'b1;
                        end
                    end
                    default:
                    begin
                        want.hit_dead_end = dead;
                        want.accepted     = !dead && cur_state < NUM_STATES
                                            && acc_flag[cur_state];
                        verdicts.insert(verdicts.size(), want);
                        cur_state = start_reg;
                        dead      = 1'b0;
                    end
                endcase
            end

            // a new start state only counts from the next string end
            if (cfg_we)
                start_reg = cfg_wdata;

            pending_verdicts <= verdicts.size();
        end
    end

endmodule

[tb/tb_dfa_string_acceptor.sv]
`timescale 1ns / 1ps

module tb_dfa_string_acceptor;
    import dsa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 250;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STATE_W-1:0] cfg_wdata;

    dsa_item_if   item_ch ();
    dsa_result_if result_ch ();

    int mismatches;
    int pending_verdicts;
    int sent;
    int cycles;
    bit hold_req;

    dfa_string_acceptor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // watches both channels and the register port, and compares every result
    dsa_match_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .item             (item_ch),
        .result           (result_ch),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .pending_verdicts (pending_verdicts)
    );

    always #6 clk = ~clk;

    // every block input at a known level from time zero
    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        item_ch.valid         = 1'b0;
        item_ch.mode          = MODE_BYTE;
        item_ch.src_state     = '0;
        item_ch.char_code     = '0;
        item_ch.dest_state    = '0;
        item_ch.edge_valid    = 1'b0;
        item_ch.accepting_bit = 1'b0;
        result_ch.ready       = 1'b0;
        sent                  = 0;
        hold_req              = 1'b0;
    end

    // offer one item and stay on it until its transfer; valid is only lowered
    // when a gap is drawn, so back-to-back items keep it high
    task automatic send(input mode_t m, input logic [5:0] s, input logic [7:0] c,
                        input logic [5:0] d, input logic ev, input logic ac);
        int gap;
        // a burst with no gaps every so often, otherwise a random gap
        gap = (sent % 128 < 24) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.mode          <= m;
        item_ch.src_state     <= s;
        item_ch.char_code     <= c;
        item_ch.dest_state    <= d;
        item_ch.edge_valid    <= ev;
        item_ch.accepting_bit <= ac;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        sent++;
    endtask

    // unused fields of each item carry random values
    task automatic wr_edge(input logic [5:0] s, input logic [7:0] c, input logic [5:0] d,
                           input logic ev);
        send(MODE_WR_EDGE, s, c, d, ev, 1'($urandom));
    endtask

    task automatic wr_acc(input logic [5:0] s, input logic ac);
        send(MODE_WR_ACC, s, 8'($urandom), 6'($urandom), 1'($urandom), ac);
    endtask

    task automatic feed(input logic [7:0] c);
        send(MODE_BYTE, 6'($urandom), c, 6'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic end_str();
        send(MODE_END, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom),
             1'($urandom));
    endtask

    // sender goes quiet until every pending result has its transfer, then lets
    // the pipeline settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_start(input logic [5:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one phase: new start state, a small automaton over a few states and
    // bytes, then mostly strings over that alphabet with some noise
    task automatic run_phase(input logic [5:0] start, input bit with_hold);
        logic [5:0] states [6];
        logic [7:0] alpha  [4];
        int         target;
        int         pick;
        int         len;
        target = sent + PHASE_ITEMS;
        set_start(start);
        states[0] = start;
        for (int i = 1; i < 6; i++)
            states[i] = 6'($urandom);
        for (int j = 0; j < 4; j++)
            alpha[j] = 8'($urandom);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 4; j++)
                wr_edge(states[i], alpha[j], states[$urandom_range(0, 5)], 1'b1);
        for (int i = 0; i < 6; i++)
            wr_acc(states[i], 1'($urandom));

        // receiver holds off while strings keep coming, so the block backs up
        if (with_hold)
            hold_req = 1'b1;

        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = $urandom_range(0, 10);
                for (int k = 0; k < len; k++)
                    feed(($urandom_range(0, 11) == 0) ? 8'($urandom)
                                                      : alpha[$urandom_range(0, 3)]);
                end_str();
            end
            else if (pick < 82)
            begin
                // rewrite or remove an edge, sometimes pointing outside the set
                wr_edge(states[$urandom_range(0, 5)], alpha[$urandom_range(0, 3)],
                        ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                    : states[$urandom_range(0, 5)],
                        $urandom_range(0, 5) != 0);
            end
            else if (pick < 88)
                wr_acc(states[$urandom_range(0, 5)], 1'($urandom));
            else if (pick < 90)
                drain();
            else
                send(mode_t'($urandom_range(0, 3)), 6'($urandom), 8'($urandom),
                     6'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // receiver: random stall before each transfer, long hold-off on request
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = (taken % 64 < 12) ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                result_ch.ready <= 1'b1;
                @(posedge clk);
                while (!result_ch.valid && !hold_req) @(posedge clk);
                if (result_ch.valid)
                    taken++;
            end
        end
    end

    // watchdog, covers the table sweep after reset as well
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: start state 0, empty table
        end_str();                       // empty string, start not accepting
        feed(8'h00);                     // no edge, string goes dead
        feed(8'hFF);                     // ignored once dead
        end_str();
        wr_edge(6'd0, 8'h00, 6'd63, 1'b1);
        wr_edge(6'd63, 8'hFF, 6'd0, 1'b1);
        wr_acc(6'd0, 1'b1);
        wr_acc(6'd63, 1'b1);
        end_str();                       // empty string, start now accepting
        feed(8'h00);
        end_str();                       // ends in state 63
        feed(8'h00);
        feed(8'hFF);
        feed(8'h00);
        feed(8'h00);                     // state 63 has no edge on 0x00
        end_str();
        wr_edge(6'd0, 8'h00, 6'd5, 1'b1); // rewrite replaces the earlier edge
        feed(8'h00);
        end_str();                       // state 5 not accepting
        wr_edge(6'd0, 8'h00, 6'd63, 1'b0); // edge removed
        feed(8'h00);
        end_str();
        wr_acc(6'd63, 1'b0);
        // new start state only applies after the next string end
        set_start(6'd63);
        end_str();                       // still judged from state 0
        feed(8'hFF);                     // now starting from 63
        end_str();

        // random phases, extremes of the start state first
        run_phase(6'd63, 1'b0);
        run_phase(6'd0, 1'b1);
        for (int p = 0; p < 4; p++)
            run_phase(6'($urandom), 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
